>>> design/bfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfm_pkg
// shared constants, codes, types and helper functions of the bloom filter
// ----------------------------------------------------------------------------
package bfm_pkg;

  // operation codes of an item
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_NUM_BITS   = 2'd0;
  localparam logic [1:0] REG_NUM_HASHES = 2'd1;
  localparam logic [1:0] REG_BASE_SEED  = 2'd2;

  // register widths
  localparam int NB_W  = 17;  // num_bits
  localparam int NH_W  = 6;   // num_hashes
  localparam int CNT_W = 7;   // capped hash count, holds up to 64

  // murmur3 constants
  localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2 = 32'h1b873593;
  localparam logic [31:0] MM_F1 = 32'h85ebca6b;
  localparam logic [31:0] MM_F2 = 32'hc2b2ae35;
  localparam logic [31:0] MM_N  = 32'he6546b64;

  // control toward the bit store
  typedef struct packed {
    logic clr;
    logic wr;
    logic rd;
  } store_ctl_t;

  function automatic logic [31:0] rotl15(input logic [31:0] x);
    rotl15 = {x[16:0], x[31:17]};
  endfunction

  function automatic logic [31:0] rotl13(input logic [31:0] x);
    rotl13 = {x[18:0], x[31:19]};
  endfunction

endpackage
`default_nettype wire

>>> design/bfm_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfm_mul
// shared 32x32 multiplier, low product word, registered output
// ----------------------------------------------------------------------------
module bfm_mul import bfm_pkg::*; (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] p
);

  logic [31:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= 32'(a * b);
  end

  assign p = p_r;

endmodule
`default_nettype wire

>>> design/bfm_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfm_mod
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module bfm_mod import bfm_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [31:0]     dividend,
  input  wire logic [NB_W-1:0] divisor,
  output logic                 done,
  output logic      [NB_W-1:0] rem
);

  logic            busy_r;
  logic            done_r;
  logic [4:0]      cnt_r;
  logic [31:0]     dvd_r;
  logic [NB_W-1:0] dsr_r;
  logic [NB_W:0]   rem_r;
  logic [NB_W:0]   trial;
  logic [NB_W:0]   rem_nxt;

  always_comb begin
    trial = {rem_r[NB_W-1:0], dvd_r[31]};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = trial - {1'b0, dsr_r};
    end else begin
      rem_nxt = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 5'd31) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[30:0], 1'b0};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 5'd1;
    end
  end

  assign done = done_r;
  assign rem  = rem_r[NB_W-1:0];

endmodule
`default_nettype wire

>>> design/bfm_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfm_store
// one-bit filter memory with a clearing sweep after reset and on request
// ----------------------------------------------------------------------------
module bfm_store import bfm_pkg::*; #(
  parameter int FILTER_BITS = 65536,
  parameter int IDXW        = $clog2(FILTER_BITS)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire store_ctl_t      ctl,
  input  wire logic [IDXW-1:0] addr,
  output logic                 busy,
  output logic                 rd_bit
);

  logic            mem [FILTER_BITS];
  logic            sweep_r;
  logic [IDXW-1:0] cnt_r;
  logic            q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= 1'b1;
      cnt_r   <= '0;
    end else if (ctl.clr) begin
      sweep_r <= 1'b1;
      cnt_r   <= '0;
    end else if (sweep_r) begin
      cnt_r <= cnt_r + IDXW'(1);
      if (cnt_r == IDXW'(FILTER_BITS - 1)) begin
        sweep_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sweep_r) begin
      mem[cnt_r] <= 1'b0;
    end else if (ctl.wr) begin
      mem[addr] <= 1'b1;
    end
    if (ctl.rd) begin
      q_r <= mem[addr];
    end
  end

  assign busy   = sweep_r;
  assign rd_bit = q_r;

endmodule
`default_nettype wire

>>> design/bloom_filter_murmur3.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bloom_filter_murmur3
// bloom filter with murmur3-32 hashing, one shared multiplier under a sequencer
// ----------------------------------------------------------------------------
// A key streams in as 32-bit little-endian words; the kind of the last word
// selects insert or query, and a clear item zeroes the filter. Every item is
// taken only while the block is idle. A key word is scrambled through the
// shared multiplier in steps K1 to K3, then the hash state memory is read
// and written once per seed. The last word adds a setup step, then two
// multiplies and a run of the remainder unit per active hash, then an
// output step. A clear, and the clearing pass after reset, sweep the bit
// store one bit a cycle; no item is taken while the sweep runs.
// Configuration writes are taken at any time (cfg_ready is always high).
// ----------------------------------------------------------------------------
module bloom_filter_murmur3 import bfm_pkg::*; #(
  parameter int FILTER_BITS = 65536,
  parameter int MAX_HASHES  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // items in
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_kind,
  input  wire logic [31:0] in_key_word,
  input  wire logic [2:0]  in_word_bytes,
  input  wire logic        in_last,
  // results out
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [1:0]  out_done_kind,
  output logic             out_found,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int IDXW = $clog2(FILTER_BITS);
  localparam int HW   = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_K1   = 4'd1;
  localparam logic [3:0] S_K2   = 4'd2;
  localparam logic [3:0] S_K3   = 4'd3;
  localparam logic [3:0] S_RRD  = 4'd4;
  localparam logic [3:0] S_RWR  = 4'd5;
  localparam logic [3:0] S_WEND = 4'd6;
  localparam logic [3:0] S_FSET = 4'd7;
  localparam logic [3:0] S_FRD  = 4'd8;
  localparam logic [3:0] S_F0   = 4'd9;
  localparam logic [3:0] S_F1   = 4'd10;
  localparam logic [3:0] S_F2   = 4'd11;
  localparam logic [3:0] S_FDIV = 4'd12;
  localparam logic [3:0] S_FQ   = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;
  localparam logic [3:0] S_CLR  = 4'd15;

  // configuration registers
  logic [NB_W-1:0] num_bits_r;
  logic [NH_W-1:0] num_hashes_r;
  logic [31:0]     seed_tweak_r;

  // sequencer and key state
  logic [3:0]       state_r;
  logic [1:0]       kind_r;
  logic             last_r;
  logic [2:0]       nb_r;
  logic [31:0]      word_r;
  logic [31:0]      k_r;
  logic             in_key_r;
  logic             use_seed_r;
  logic [31:0]      seed_base_r;
  logic [31:0]      key_len_r;
  logic [HW-1:0]    i_r;
  logic [NB_W-1:0]  bits_r;
  logic [CNT_W-1:0] count_r;
  logic             found_r;

  // output register
  logic       out_valid_r;
  logic [1:0] out_kind_r;
  logic       out_found_r;

  // hash state memory, seeded lazily through use_seed_r
  logic [31:0] hs_mem [MAX_HASHES];
  logic [31:0] hs_q_r;
  logic        hs_we;
  logic [31:0] hs_wdata;

  // shared units
  logic [31:0]     mul_a;
  logic [31:0]     mul_b;
  logic [31:0]     mul_p;
  logic            div_start;
  logic [31:0]     div_dvd;
  logic            div_done;
  logic [NB_W-1:0] div_rem;
  store_ctl_t      st_ctl;
  logic [IDXW-1:0] st_addr;
  logic            st_busy;
  logic            st_bit;

  // combinational helpers
  logic                 accept;
  logic [2:0]           nb_eff;
  logic [31:0]          word_mask;
  logic [31:0]          hs_base;
  logic [31:0]          rnd_x;
  logic [31:0]          rnd_r;
  logic [31:0]          fin_h;
  logic [NB_W-1:0]      bits_cap;
  logic [CNT_W-1:0]     count_cap;
  logic [IDXW+NB_W-1:0] rem_ext;
  logic                 last_idx;
  logic                 out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE) || st_busy;
  assign cfg_ready = 1'b1;
  assign out_free = !out_valid_r || !out_stall;

  // config writes, index 3 is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bits_r   <= '0;
      num_hashes_r <= NH_W'(1);
      seed_tweak_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NUM_BITS:   num_bits_r   <= cfg_data[NB_W-1:0];
        REG_NUM_HASHES: num_hashes_r <= cfg_data[NH_W-1:0];
        REG_BASE_SEED:  seed_tweak_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // short words before the last one count as full words
  always_comb begin
    if (!in_last || in_word_bytes >= 3'd4) begin
      nb_eff = 3'd4;
    end else begin
      nb_eff = in_word_bytes;
    end
    unique case (nb_eff)
      3'd1:    word_mask = {24'd0, in_key_word[7:0]};
      3'd2:    word_mask = {16'd0, in_key_word[15:0]};
      3'd3:    word_mask = {8'd0, in_key_word[23:0]};
      default: word_mask = in_key_word;
    endcase
  end

  // capped registers, read at the last word
  always_comb begin
    if ({{(21 - NB_W){1'b0}}, num_bits_r} > 21'(FILTER_BITS)) begin
      bits_cap = NB_W'(FILTER_BITS);
    end else begin
      bits_cap = num_bits_r;
    end
    if ({1'b0, num_hashes_r} > CNT_W'(MAX_HASHES)) begin
      count_cap = CNT_W'(MAX_HASHES);
    end else begin
      count_cap = {1'b0, num_hashes_r};
    end
  end

  // per-seed state: seeds stand in until the first round writes the memory
  assign hs_base  = use_seed_r ? (seed_base_r + 32'(i_r)) : hs_q_r;
  assign rnd_x    = hs_base ^ k_r;
  assign rnd_r    = rotl13(rnd_x);
  assign last_idx = (i_r == HW'(MAX_HASHES - 1));

  always_comb begin
    hs_we    = (state_r == S_RWR);
    hs_wdata = rnd_x;
    if (nb_r == 3'd4) begin
      hs_wdata = rnd_r + {rnd_r[29:0], 2'b00} + MM_N;
    end
  end

  always_ff @(posedge clk) begin
    if (hs_we) begin
      hs_mem[i_r] <= hs_wdata;
    end
    hs_q_r <= hs_mem[i_r];
  end

  // multiplier operand selection by step
  always_comb begin
    fin_h = hs_base ^ key_len_r;
    fin_h = fin_h ^ (fin_h >> 16);
    mul_a = word_r;
    mul_b = MM_C1;
    div_start = 1'b0;
    div_dvd   = mul_p ^ (mul_p >> 16);
    unique case (state_r)
      S_K2: begin
        mul_a = rotl15(mul_p);
        mul_b = MM_C2;
      end
      S_F0: begin
        mul_a = fin_h;
        mul_b = MM_F1;
      end
      S_F1: begin
        mul_a = mul_p ^ (mul_p >> 13);
        mul_b = MM_F2;
      end
      S_F2: div_start = 1'b1;
      default: ;
    endcase
  end

  // bit index from the remainder, zero-extended or trimmed to the store
  assign rem_ext = {{IDXW{1'b0}}, div_rem};
  assign st_addr = rem_ext[IDXW-1:0];

  always_comb begin
    st_ctl.clr = accept && (in_kind == KIND_CLEAR);
    st_ctl.wr  = (state_r == S_FDIV) && div_done && (kind_r == KIND_INSERT);
    st_ctl.rd  = (state_r == S_FDIV) && div_done && (kind_r == KIND_QUERY);
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_key_r   <= 1'b0;
      use_seed_r <= 1'b0;
      key_len_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            kind_r <= in_kind;
            unique case (in_kind)
              KIND_CLEAR: begin
                in_key_r  <= 1'b0;
                key_len_r <= '0;
                state_r   <= S_CLR;
              end
              KIND_NONE: ;
              default: begin
                last_r <= in_last;
                nb_r   <= nb_eff;
                word_r <= word_mask;
                if (!in_key_r) begin
                  // seeds are taken at the first word of a key
                  in_key_r    <= 1'b1;
                  use_seed_r  <= 1'b1;
                  key_len_r   <= '0;
                  seed_base_r <= 32'(seed_tweak_r * 32'(MAX_HASHES));
                end
                state_r <= (nb_eff == 3'd0) ? S_WEND : S_K1;
              end
            endcase
          end
        end
        S_K1: state_r <= S_K2;
        S_K2: state_r <= S_K3;
        S_K3: begin
          k_r     <= mul_p;
          i_r     <= '0;
          state_r <= S_RRD;
        end
        S_RRD: state_r <= S_RWR;
        S_RWR: begin
          if (last_idx) begin
            use_seed_r <= 1'b0;
            state_r    <= S_WEND;
          end else begin
            i_r     <= i_r + HW'(1);
            state_r <= S_RRD;
          end
        end
        S_WEND: begin
          key_len_r <= key_len_r + 32'(nb_r);
          state_r   <= last_r ? S_FSET : S_IDLE;
        end
        S_FSET: begin
          bits_r  <= bits_cap;
          count_r <= count_cap;
          found_r <= (bits_cap != '0);
          i_r     <= '0;
          // filter off or no hashes: answer right away
          if (bits_cap == '0 || count_cap == '0) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_FRD;
          end
        end
        S_FRD: state_r <= S_F0;
        S_F0:  state_r <= S_F1;
        S_F1:  state_r <= S_F2;
        S_F2:  state_r <= S_FDIV;
        S_FDIV: begin
          if (div_done) begin
            state_r <= S_FQ;
          end
        end
        S_FQ: begin
          if (kind_r == KIND_QUERY && !st_bit) begin
            found_r <= 1'b0;
          end
          if (CNT_W'(i_r) + CNT_W'(1) == count_r) begin
            state_r <= S_OUT;
          end else begin
            i_r     <= i_r + HW'(1);
            state_r <= S_FRD;
          end
        end
        S_OUT: begin
          if (out_free) begin
            in_key_r  <= 1'b0;
            key_len_r <= '0;
            state_r   <= S_IDLE;
          end
        end
        S_CLR: begin
          // sweep flag is already set the cycle after the request
          if (!st_busy) begin
            found_r <= 1'b0;
            state_r <= S_OUT;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result register, refilled only when the previous item has left
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_kind_r  <= kind_r;
      out_found_r <= (kind_r == KIND_QUERY) && found_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_done_kind = out_kind_r;
  assign out_found     = out_found_r;

  bfm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  bfm_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (bits_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  bfm_store #(
    .FILTER_BITS (FILTER_BITS),
    .IDXW        (IDXW)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (st_ctl),
    .addr   (st_addr),
    .busy   (st_busy),
    .rd_bit (st_bit)
  );

endmodule
`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the murmur3 bloom filter
// ----------------------------------------------------------------------------
// Keys are streamed in as word items under several register settings, with
// random gaps on the input and random stalls on the output. A scoreboard
// mirrors the bit store and the per-seed hash states, and predicts the
// done kind and found flag of every finished operation.
// ----------------------------------------------------------------------------
module tb_top;
  import bfm_pkg::*;

  localparam int STORE_SIZE = 65536;
  localparam int SEED_COUNT = 32;
  localparam int IDLE_LIMIT = 300000;

  typedef bit [31:0] word_q_t[$];

  // mirror of the filter: bit store, hash states and registers
  class bloom_scoreboard;
    typedef struct {
      bit [1:0] kind;
      bit       found;
    } outcome_t;

    bit        store_bits[STORE_SIZE];
    bit [31:0] seed_state[SEED_COUNT];
    bit [31:0] byte_count;
    bit        in_progress;
    bit [16:0] num_bits;
    bit [5:0]  num_hashes;
    bit [31:0] seed_tweak;
    outcome_t  pending[$];
    int        errors;

    function new();
      foreach (store_bits[i]) store_bits[i] = 0;
      byte_count  = 0;
      in_progress = 0;
      num_bits    = 0;
      num_hashes  = 1;
      seed_tweak  = 0;
      errors      = 0;
    endfunction

    function bit [31:0] rot(input bit [31:0] x, input int r);
      return (x << r) | (x >> (32 - r));
    endfunction

    function bit [31:0] mix_word(input bit [31:0] k);
      bit [31:0] t;
      t = k * 32'hcc9e2d51;
      t = rot(t, 15);
      return t * 32'h1b873593;
    endfunction

    function bit [31:0] avalanche(input bit [31:0] h);
      bit [31:0] t;
      t = h ^ (h >> 16);
      t = t * 32'h85ebca6b;
      t = t ^ (t >> 13);
      t = t * 32'hc2b2ae35;
      return t ^ (t >> 16);
    endfunction

    function void write_reg(input bit [1:0] idx, input bit [31:0] d);
      case (idx)
        REG_NUM_BITS:   num_bits = d[16:0];
        REG_NUM_HASHES: num_hashes = d[5:0];
        REG_BASE_SEED:  seed_tweak = d;
        default: ;
      endcase
    endfunction

    function void note_item(input bit [1:0] kind, input bit [31:0] word,
                            input bit [2:0] nb, input bit last);
      outcome_t  o;
      bit [31:0] k;
      bit [31:0] h;
      bit [31:0] n;
      bit [31:0] span;
      bit [31:0] pos;
      int        cnt;
      bit        hit;
      if (kind == KIND_NONE) return;
      if (kind == KIND_CLEAR) begin
        foreach (store_bits[i]) store_bits[i] = 0;
        in_progress = 0;
        byte_count  = 0;
        o.kind  = KIND_CLEAR;
        o.found = 0;
        pending = {pending, o};
        return;
      end
      if (!in_progress) begin
        for (int i = 0; i < SEED_COUNT; i++) seed_state[i] = seed_tweak * SEED_COUNT + i;
        byte_count  = 0;
        in_progress = 1;
      end
      n = (!last || nb >= 4) ? 4 : nb;
      if (n == 4) begin
        k = mix_word(word);
        for (int i = 0; i < SEED_COUNT; i++) begin
          h = rot(seed_state[i] ^ k, 13);
          seed_state[i] = h * 5 + 32'he6546b64;
        end
      end else if (n != 0) begin
        k = mix_word(word & ((32'h1 << (8 * n)) - 1));
        for (int i = 0; i < SEED_COUNT; i++) seed_state[i] ^= k;
      end
      byte_count += n;
      if (!last) return;
      // oversized registers saturate to the store size and the seed count
      span = (num_bits > STORE_SIZE) ? STORE_SIZE : num_bits;
      cnt  = (num_hashes > SEED_COUNT) ? SEED_COUNT : num_hashes;
      hit  = (span != 0);
      if (span != 0) begin
        for (int i = 0; i < cnt; i++) begin
          pos = avalanche(seed_state[i] ^ byte_count) % span;
          if (kind == KIND_INSERT) store_bits[pos] = 1;
          else if (!store_bits[pos]) hit = 0;
        end
      end
      in_progress = 0;
      byte_count  = 0;
      o.kind  = kind;
      o.found = (kind == KIND_QUERY) && hit;
      pending = {pending, o};
    endfunction

    function void check_result(input bit [1:0] kind, input bit found);
      outcome_t o;
      if (pending.size() == 0) begin
        $error("result with nothing expected: done_kind %0d found %0d", kind, found);
        errors++;
        return;
      end
      o = pending.pop_front();
      if (o.kind != kind) begin
        $error("done_kind expected %0d actual %0d", o.kind, kind);
        errors++;
      end
      if (o.found != found) begin
        $error("found expected %0d actual %0d", o.found, found);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic [31:0] in_key_word;
  logic [2:0]  in_word_bytes;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_done_kind;
  logic        out_found;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  bloom_scoreboard sb = new();

  // long receiver hold-off request, served once by the receiver process
  bit hold_req;
  bit hold_done;
  int clears_left;
  int idle_cycles;
  word_q_t   key_pool[8];
  bit [2:0]  pool_tail[8];
  int        pool_fill;

  bloom_filter_murmur3 u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_key_word  (in_key_word),
    .in_word_bytes(in_word_bytes),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_done_kind(out_done_kind),
    .out_found    (out_found),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side: random stall runs, free stretches, one long hold-off
  int stall_run;
  int free_run;
  int hold_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_run <= 0;
      free_run  <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 3000;
      out_stall <= 1'b1;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else if (free_run > 0) begin
      out_stall <= 1'b0;
      free_run  <= free_run - 1;
    end else begin
      out_stall <= 1'b0;
      stall_run <= pick_gap();
      free_run  <= ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(0, 6);
    end
  end

  // accepted results go straight to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_done_kind, out_found);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(input bit [1:0] kind, input bit [31:0] word,
                           input bit [2:0] nb, input bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_key_word   <= word;
    in_word_bytes <= nb;
    in_last       <= last;
    do @(posedge clk); while (in_stall);
    sb.note_item(kind, word, nb, last);
  endtask

  // leaves cfg_valid high so that writes can follow back to back
  task automatic write_reg(input bit [1:0] idx, input bit [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
  endtask

  // drain results and let any result-free work finish before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_regs(input bit [31:0] nbits, input bit [31:0] nhash,
                          input bit [31:0] seed);
    settle();
    write_reg(REG_NUM_BITS, nbits);
    write_reg(REG_NUM_HASHES, nhash);
    write_reg(REG_BASE_SEED, seed);
    cfg_valid <= 1'b0;
  endtask

  function automatic bit [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  // stream one key; middle words take random kinds and sometimes short counts
  task automatic send_key(input bit [1:0] final_kind, input word_q_t words,
                          input bit [2:0] tail);
    bit [1:0] k;
    bit [2:0] nb;
    bit       last;
    foreach (words[i]) begin
      last = (i == words.size() - 1);
      k    = last ? final_kind : 2'($urandom_range(0, 1));
      nb   = last ? tail : (($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7)) : 3'd4);
      send_item(k, words[i], nb, last);
    end
  endtask

  task automatic random_keys(input int n_items);
    int       sent;
    int       slot;
    int       len;
    word_q_t  words;
    bit [2:0] tail;
    bit [1:0] fk;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 19) == 0) begin
        // noise: unused kind or, rarely, a clear
        if (clears_left > 0 && $urandom_range(0, 5) == 0) begin
          clears_left--;
          send_item(KIND_CLEAR, pick_word(), 3'($urandom_range(0, 7)), 1'($urandom));
        end else begin
          send_item(KIND_NONE, pick_word(), 3'($urandom_range(0, 7)), 1'($urandom));
        end
        sent++;
        continue;
      end
      fk = ($urandom_range(0, 1) == 0) ? KIND_INSERT : KIND_QUERY;
      if (pool_fill > 0 && $urandom_range(0, 2) == 0) begin
        // revisit a known key so that queries often hit
        slot  = $urandom_range(0, pool_fill - 1);
        words = key_pool[slot];
        tail  = pool_tail[slot];
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 3);
        words = {};
        repeat (len) words = {words, pick_word()};
        tail = 3'($urandom_range(0, 7));
        if (pool_fill < 8) begin
          slot = pool_fill;
          pool_fill++;
        end else begin
          slot = $urandom_range(0, 7);
        end
        key_pool[slot]  = words;
        pool_tail[slot] = tail;
        fk = KIND_INSERT;
        if ($urandom_range(0, 3) == 0) fk = KIND_QUERY;
      end
      send_key(fk, words, tail);
      sent += words.size();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_kind       = KIND_NONE;
    in_key_word   = '0;
    in_word_bytes = '0;
    in_last       = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_NUM_BITS;
    cfg_data      = '0;
    hold_req      = 1'b0;
    clears_left   = 4;
    pool_fill     = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // filter disabled by reset value: query answers zero
    send_item(KIND_INSERT, 32'h12345678, 3'd4, 1'b1);
    send_item(KIND_QUERY, 32'h12345678, 3'd4, 1'b1);

    set_regs(64, 3, 32'h1);
    send_item(KIND_INSERT, 32'hffffffff, 3'd4, 1'b1);
    send_item(KIND_QUERY, 32'hffffffff, 3'd4, 1'b1);
    send_item(KIND_QUERY, 32'h0, 3'd4, 1'b1);
    // tail counts 0 through 7, with 5..7 acting as a full word
    for (int b = 0; b < 8; b++) send_item(KIND_INSERT, 32'ha5c3_96f1, 3'(b), 1'b1);
    // multi-word key with a short middle word and mixed kinds
    send_item(KIND_QUERY, 32'h0, 3'd1, 1'b0);
    send_item(KIND_INSERT, 32'hdeadbeef, 3'd0, 1'b0);
    send_item(KIND_QUERY, 32'h80000001, 3'd3, 1'b1);
    send_item(KIND_NONE, 32'hffffffff, 3'd7, 1'b1);
    send_item(KIND_CLEAR, 32'h0, 3'd0, 1'b0);
    send_item(KIND_QUERY, 32'hffffffff, 3'd4, 1'b1);

    // no hashes: query answers one
    set_regs(100, 0, 32'h0);
    send_item(KIND_QUERY, 32'h55aa55aa, 3'd2, 1'b1);

    set_regs(STORE_SIZE, SEED_COUNT, 32'hffffffff);
    random_keys(110);
    set_regs(131071, 63, $urandom);
    random_keys(60);
    set_regs(8, 2, $urandom);
    random_keys(150);
    // receiver holds off while the sender keeps offering items
    set_regs(16, 4, $urandom);
    hold_req <= 1'b1;
    random_keys(150);
    set_regs(1, 1, 32'h0);
    random_keys(100);
    set_regs(1000, 6, $urandom);
    random_keys(150);
    set_regs(0, 5, $urandom);
    random_keys(60);
    set_regs(40, 8, $urandom);
    random_keys(150);

    settle();
    repeat (2000) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/bfm_pkg.sv
design/bfm_mul.sv
design/bfm_mod.sv
design/bfm_store.sv
design/bloom_filter_murmur3.sv
sim/tb_top.sv
